/* rtl/core/crc64bs_pkg.sv */
// ----------------------------------------------------------------------------
// crc64bs_pkg
// Shared types, constants and the byte table function for the CRC-64/XZ
// byte stream block.
// ----------------------------------------------------------------------------
package crc64bs_pkg;

  localparam int unsigned CRC_W  = 64;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  // Reflected ECMA-182 polynomial (bit reversal of 0x42F0E1EBA9EA3693)
  localparam logic [CRC_W-1:0] CRC_POLY_REFL = 64'hC96C_5795_D787_0F42;

  // One word held in the input register
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BYTE_W-1:0] data;
  } stage_t;

  // Table entry: eight reflected shift steps starting from the index
  function automatic logic [CRC_W-1:0] crc_table(input logic [BYTE_W-1:0] idx);
    logic [CRC_W-1:0] v;
    v = {{(CRC_W-BYTE_W){1'b0}}, idx};
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY_REFL;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

/* rtl/core/crc64bs_in_reg.sv */
// ----------------------------------------------------------------------------
// crc64bs_in_reg
// Input register: captures one byte word and its last mark per cycle while in_ready is high.
// ----------------------------------------------------------------------------
module crc64bs_in_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crc64bs_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                           in_last_byte,
  input  logic                           pop,
  output crc64bs_pkg::stage_t            stage
);

  logic                           valid_r;
  logic                           valid_nxt;
  logic                           last_r;
  logic [crc64bs_pkg::BYTE_W-1:0] data_r;

  assign in_ready  = !valid_r || pop;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign stage = '{valid: valid_r, last: last_r, data: data_r};

endmodule

/* rtl/core/crc64bs_engine.sv */
// ----------------------------------------------------------------------------
// crc64bs_engine
// CRC register and the one-byte reflected update.
// ----------------------------------------------------------------------------
module crc64bs_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crc64bs_pkg::stage_t           stage,
  input  logic                          fire,
  output logic [crc64bs_pkg::CRC_W-1:0] crc_final,
  output logic [crc64bs_pkg::CRC_W-1:0] crc_state
);

  logic [crc64bs_pkg::CRC_W-1:0] crc_r;
  logic [crc64bs_pkg::CRC_W-1:0] crc_nxt;
  logic [crc64bs_pkg::CRC_W-1:0] fold;

  assign fold = crc64bs_pkg::crc_table(crc_r[crc64bs_pkg::BYTE_W-1:0] ^ stage.data)
                ^ (crc_r >> crc64bs_pkg::BYTE_W);

  always_comb begin
    crc_nxt = crc_r;
    if (fire) begin
      // message ends: restart with the seed for the next one
      crc_nxt = stage.last ? crc64bs_pkg::CRC_ALL_ONES : fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= crc64bs_pkg::CRC_ALL_ONES;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc_final = fold ^ crc64bs_pkg::CRC_ALL_ONES;
  assign crc_state = crc_r;

endmodule

/* rtl/core/crc64bs_out_reg.sv */
// ----------------------------------------------------------------------------
// crc64bs_out_reg
// Result register: holds one finished CRC word until it is taken.
// ----------------------------------------------------------------------------
module crc64bs_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [crc64bs_pkg::CRC_W-1:0] value,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crc64bs_pkg::CRC_W-1:0] out_crc_value
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [crc64bs_pkg::CRC_W-1:0] crc_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crc_r <= value;
    end
  end

  assign out_valid     = valid_r;
  assign out_crc_value = crc_r;

endmodule

/* rtl/core/crc64_byte_stream.sv */
// ----------------------------------------------------------------------------
// crc64_byte_stream
// Byte-serial CRC-64/XZ over a stream of messages.
// ----------------------------------------------------------------------------
// Takes one message byte per clock and folds it into a 64-bit CRC (reflected
// ECMA-182 polynomial, seed all ones). A byte marked last yields one word
// holding the final CRC inverted, and the register reloads all ones for the
// next message. Throughput is one byte per cycle outside stalls, set by the
// combinational table fold between the input register and the CRC register;
// a last byte passes the input register, then the result register. Input
// stalls only while a last byte waits behind a result word not yet taken.
// ----------------------------------------------------------------------------
module crc64_byte_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crc64bs_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crc64bs_pkg::CRC_W-1:0]  out_crc_value
);

  crc64bs_pkg::stage_t           stage;
  logic                          fire;
  logic                          out_free;
  logic [crc64bs_pkg::CRC_W-1:0] crc_final;
  logic [crc64bs_pkg::CRC_W-1:0] crc_state;

  // non-last words never need the result register
  assign fire = stage.valid && (!stage.last || out_free);

  crc64bs_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .pop          (fire),
    .stage        (stage)
  );

  crc64bs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .fire      (fire),
    .crc_final (crc_final),
    .crc_state (crc_state)
  );

  crc64bs_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (fire && stage.last),
    .value         (crc_final),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_crc_value (out_crc_value)
  );

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stage.last |=> out_valid)
    else $error("last word did not produce a result");

  a_seed_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stage.last |=> crc_state == crc64bs_pkg::CRC_ALL_ONES)
    else $error("CRC not reseeded after last word");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> stage.valid && stage.last && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_idle_crc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(crc_state))
    else $error("CRC changed without a word");
`endif

endmodule

/* test/crc64_byte_stream_tb.sv */
// ----------------------------------------------------------------------------
// crc64_byte_stream_tb
// Self-checking bench for the byte-serial CRC-64/XZ block. A bitwise CRC
// model tracks every accepted byte and queues the inverted CRC on each last
// byte. Every result word is compared against that queue. The run covers
// directed messages, then random messages under several idle and stall
// mixes, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module crc64_byte_stream_tb;

  localparam int unsigned IDLE_LIMIT = 2000;  // cycles with no word moving
  localparam int unsigned TAIL_CYCLES = 8;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [crc64bs_pkg::BYTE_W-1:0] in_data_byte = '0;
  logic                           in_last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [crc64bs_pkg::CRC_W-1:0]  out_crc_value;

  logic [crc64bs_pkg::CRC_W-1:0]  crc_running;
  logic [crc64bs_pkg::CRC_W-1:0]  crc_expected_q[$];
  int                             mismatch_count = 0;
  int                             send_idle_pct = 0;
  int                             recv_stall_pct = 0;
  int                             hold_request = 0;
  int                             hold_left = 0;
  int                             quiet_cycles = 0;

  crc64_byte_stream uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_crc_value(out_crc_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bitwise reflected fold; matches the byte-table form by linearity
  function automatic logic [crc64bs_pkg::CRC_W-1:0] crc_fold_byte(
      input logic [crc64bs_pkg::CRC_W-1:0]  crc,
      input logic [crc64bs_pkg::BYTE_W-1:0] b);
    logic [crc64bs_pkg::CRC_W-1:0] r;
    r = crc ^ {{(crc64bs_pkg::CRC_W-crc64bs_pkg::BYTE_W){1'b0}}, b};
    for (int k = 0; k < crc64bs_pkg::BYTE_W; k++) begin
      r = r[0] ? ((r >> 1) ^ crc64bs_pkg::CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Predictor: folds each accepted byte, queues the CRC on the last one
  always @(posedge clk) begin
    if (!rst_n) begin
      crc_running = crc64bs_pkg::CRC_ALL_ONES;
    end else if (in_valid && in_ready) begin
      if (in_last_byte) begin
        crc_expected_q.push_back(crc_fold_byte(crc_running, in_data_byte)
                                 ^ crc64bs_pkg::CRC_ALL_ONES);
        crc_running = crc64bs_pkg::CRC_ALL_ONES;
      end else begin
        crc_running = crc_fold_byte(crc_running, in_data_byte);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    logic [crc64bs_pkg::CRC_W-1:0] exp_crc;
    if (rst_n && out_valid && out_ready) begin
      if (crc_expected_q.size() == 0) begin
        note_failure($sformatf("unexpected word crc_value=%016h", out_crc_value));
      end else begin
        exp_crc = crc_expected_q.pop_front();
        if (out_crc_value !== exp_crc) begin
          note_failure($sformatf("crc_value mismatch: expected %016h actual %016h",
                                 exp_crc, out_crc_value));
        end
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which no word moves on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [crc64bs_pkg::BYTE_W-1:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_idle_gap();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (crc_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Mostly short messages, now and then a longer one
  task automatic send_random_messages(input int n_bytes, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(9) == 0) len = $urandom_range(64, 17);
      else len = $urandom_range(max_len, 1);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_directed_vectors();
    string check_str;
    check_str = "123456789";
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // one-byte messages at the byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    // standard check string
    for (int i = 0; i < check_str.len(); i++) begin
      send_byte(check_str[i], i == check_str.len() - 1);
    end
    for (int i = 0; i < 4; i++) send_byte(8'hFF, i == 3);
    for (int i = 0; i < 4; i++) send_byte(8'h00, i == 3);
    send_idle_gap();
  endtask

  task automatic test_random_back_to_back();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_messages(300, 16);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 70;
    recv_stall_pct = 0;
    send_random_messages(250, 16);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 70;
    send_random_messages(250, 8);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 25;
    recv_stall_pct = 25;
    send_random_messages(250, 16);
  endtask

  // Receiver holds off while short messages keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_idle_gap();
    hold_request = 300;
    send_random_messages(120, 2);
  endtask

  // Sender stops until every word is out, then resumes
  task automatic test_pause_until_drained();
    send_idle_pct = 10;
    recv_stall_pct = 30;
    send_random_messages(60, 12);
    send_idle_gap();
    wait_for_drain();
    send_random_messages(60, 12);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_vectors();
    test_random_back_to_back();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();
    test_pause_until_drained();

    send_idle_gap();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* crc64_byte_stream.f */
rtl/core/crc64bs_pkg.sv
rtl/core/crc64bs_in_reg.sv
rtl/core/crc64bs_engine.sv
rtl/core/crc64bs_out_reg.sv
rtl/core/crc64_byte_stream.sv
test/crc64_byte_stream_tb.sv
